### design/rasant_to_rtcm2_converter_macros.svh
// ---------------------------------------------------------------------------
// RASANT to RTCM 2 converter: assertion macros
// Shared implication checks, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef RASANT_TO_RTCM2_CONVERTER_MACROS_SVH
`define RASANT_TO_RTCM2_CONVERTER_MACROS_SVH

// same-cycle implication
`define RASRTCM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RASRTCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/rasrtcm_pkg.sv
// ---------------------------------------------------------------------------
// RASANT to RTCM 2 converter: package
// Word types, codes, satellite table entry and framing helpers.
// ---------------------------------------------------------------------------
package rasrtcm_pkg;

	localparam int NUM_SATS = 32;
	localparam int SAT_AW   = $clog2(NUM_SATS);

	typedef struct packed {
		logic [4:0]  group_bits;
		logic [15:0] block_c;
		logic [15:0] block_d;
	} in_word_t;

	typedef struct packed {
		logic [6:0] out_byte;
		logic       last;
		logic [1:0] status;
	} out_word_t;

	typedef struct packed {
		logic       scale;
		logic [1:0] udre;
		logic [15:0] range_corr;
		logic [7:0] rate_corr;
		logic [7:0] issue;
	} sat_entry_t;

	typedef struct packed {
		logic       start;
		logic [1:0] status;
		logic [2:0] nwords;
	} frm_ctl_t;

	localparam logic [1:0] ST_DATA       = 2'd0;
	localparam logic [1:0] ST_OPT        = 2'd1;
	localparam logic [1:0] ST_UNASSIGNED = 2'd2;

	localparam logic [2:0] MT_REF   = 3'd0;
	localparam logic [2:0] MT_CORR1 = 3'd1;
	localparam logic [2:0] MT_CORR2 = 3'd2;
	localparam logic [2:0] MT_COORD = 3'd3;
	localparam logic [2:0] MT_OPT   = 3'd4;
	localparam logic [2:0] MT_SKIP  = 3'd5;

	localparam logic [7:0] PREAMBLE = 8'h66;

	localparam logic [31:0] PMASK [6] = '{
		32'hbb1f3480, 32'h5d8f9a40, 32'haec7cd00,
		32'h5763e680, 32'h6bb1f340, 32'h8b7a89c0
	};
	localparam logic [31:0] DATA_MASK = 32'h3fffffc0;

	typedef enum logic [1:0] {TS_IDLE, TS_BUILD, TS_SEND} top_state_t;
	typedef enum logic       {FS_IDLE, FS_BUSY} frm_state_t;

	function automatic logic [5:0] rev6(input logic [5:0] v);
		logic [5:0] r;
		for (int i = 0; i < 6; i++) r[5 - i] = v[i];
		return r;
	endfunction

endpackage

### design/rasrtcm_sat_ram.sv
// ---------------------------------------------------------------------------
// RASANT to RTCM 2 converter: satellite table RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rasrtcm_sat_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [rasrtcm_pkg::SAT_AW-1:0] waddr,
	input  rasrtcm_pkg::sat_entry_t     wdata,
	input  logic [rasrtcm_pkg::SAT_AW-1:0] raddr,
	output rasrtcm_pkg::sat_entry_t     rdata
);
	import rasrtcm_pkg::*;

	sat_entry_t mem [NUM_SATS];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### design/rasrtcm_framer.sv
// ---------------------------------------------------------------------------
// RASANT to RTCM 2 converter: word framer
// Adds chained parity to each word and sends it as five Magnavox bytes.
// ---------------------------------------------------------------------------
`include "rasant_to_rtcm2_converter_macros.svh"

module rasrtcm_framer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rasrtcm_pkg::frm_ctl_t  ctl,
	input  logic [23:0]            word_data,
	output logic [2:0]             word_idx,
	output logic                   busy,
	output logic                   out_valid,
	input  logic                   out_stall,
	output rasrtcm_pkg::out_word_t out_data
);
	import rasrtcm_pkg::*;

	frm_state_t state_q, state_d;
	logic [1:0] status_q;
	logic [2:0] nwords_q, widx_q, bidx_q;
	logic [1:0] pp_q;
	logic       out_valid_q;
	out_word_t  out_data_q;

	logic [31:0] full, wp;
	logic [5:0]  par, sel;
	logic        space, load, fin;

	always_comb begin
		full = {pp_q, word_data, 6'b0};
		for (int j = 0; j < 6; j++) par[5 - j] = ^(full & PMASK[j]);
		wp = full | {26'b0, par};
		if (wp[30]) wp = wp ^ DATA_MASK;
		case (bidx_q)
			3'd0:    sel = wp[29:24];
			3'd1:    sel = wp[23:18];
			3'd2:    sel = wp[17:12];
			3'd3:    sel = wp[11:6];
			default: sel = wp[5:0];
		endcase
	end

	assign space = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		load = 1'b0;
		fin = 1'b0;
		case (state_q)
			FS_IDLE: begin
				if (ctl.start) state_d = FS_BUSY;
			end
			FS_BUSY: begin
				if (space) begin
					load = 1'b1;
					if (status_q != ST_DATA) fin = 1'b1;
					else if (bidx_q == 3'd4 && widx_q == nwords_q - 3'd1) fin = 1'b1;
					if (fin) state_d = FS_IDLE;
				end
			end
			default: state_d = FS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FS_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pp_q <= 2'b0;
			status_q <= ST_DATA;
			nwords_q <= 3'd0;
			widx_q <= 3'd0;
			bidx_q <= 3'd0;
		end else begin
			if (ctl.start && state_q == FS_IDLE) begin
				status_q <= ctl.status;
				nwords_q <= ctl.nwords;
				widx_q <= 3'd0;
				bidx_q <= 3'd0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
				if (status_q == ST_DATA) begin
					if (bidx_q == 3'd4) begin
						bidx_q <= 3'd0;
						widx_q <= widx_q + 3'd1;
						pp_q <= wp[1:0];
					end else begin
						bidx_q <= bidx_q + 3'd1;
					end
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q.last <= fin;
			out_data_q.status <= status_q;
			out_data_q.out_byte <= (status_q == ST_DATA) ? {1'b1, rev6(sel)} : 7'd0;
		end
	end

	assign word_idx  = widx_q;
	assign busy      = (state_q == FS_BUSY);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`RASRTCM_ASSERT_NOW(a_start_idle, ctl.start, state_q == FS_IDLE, "start while busy")
	`RASRTCM_ASSERT_NOW(a_status_zero, out_valid_q && out_data_q.status != ST_DATA, out_data_q.out_byte == 7'd0 && out_data_q.last, "bad status item")
	`RASRTCM_ASSERT_NOW(a_data_mark, out_valid_q && out_data_q.status == ST_DATA, out_data_q.out_byte[6], "data byte lacks marker")
	`RASRTCM_ASSERT_NEXT(a_fin_idle, load && fin, state_q == FS_IDLE, "framer did not finish")

endmodule

### design/rasant_to_rtcm2_converter.sv
// ---------------------------------------------------------------------------
// RASANT to RTCM 2 converter: top level
// Decodes RASANT groups, keeps station and satellite tables, builds RTCM 2
// messages and hands their words to the framer.
// ---------------------------------------------------------------------------
// channel   direction  word
// in        sink       group_bits, block_c, block_d
// out       source     out_byte, last, status
// cfg       sink       output_enable (write only)
//
// Accept reads the satellite RAM; the next cycle modifies, writes back and
// builds; bytes then pass the framer's busy state and output register, one
// per cycle while out_stall is low. A type 9 group gives 35 bytes, a status
// group one status item, a group with no output (type five, coordinate index
// three, output disabled) none; in_stall holds new groups off until idle.
// Reset clears all tables; the satellite RAM reads as zero until written.
// ---------------------------------------------------------------------------
module rasant_to_rtcm2_converter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  rasrtcm_pkg::in_word_t  in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output rasrtcm_pkg::out_word_t out_data,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata
);
	import rasrtcm_pkg::*;

	top_state_t state_q, state_d;
	logic        oe_q;
	logic [12:0] z_q;
	logic [9:0]  sid_q;
	logic [2:0]  health_q;
	logic [31:0] coord_q [3];
	logic [SAT_AW-1:0] cur_q;
	logic [2:0]  seq_q;
	logic [NUM_SATS-1:0] vld_q;
	logic        rd_vld_s1;
	in_word_t    in_q;
	logic [23:0] w_q [7];

	logic        accept;
	sat_entry_t  rd_data, old_e, new_e;
	logic        ram_we;
	frm_ctl_t    ctl;
	logic [2:0]  word_idx;
	logic        fr_busy;
	logic [2:0]  mt;
	logic [1:0]  low;
	logic        build;
	logic [5:0]  mtype;
	logic [4:0]  mlen;
	logic [2:0]  nw;
	logic [23:0] wn [7];

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != TS_IDLE);
	assign mt  = in_q.group_bits[4:2];
	assign low = in_q.group_bits[1:0];

	rasrtcm_sat_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cur_q),
		.wdata (new_e),
		.raddr (in_data.block_d[15:11]),
		.rdata (rd_data)
	);

	always_comb begin
		old_e = rd_vld_s1 ? rd_data : '0;
		new_e = old_e;
		new_e.udre = low;
		new_e.range_corr = in_q.block_c;
		if (mt == MT_CORR1) begin
			new_e.scale = in_q.block_d[9];
			new_e.rate_corr = in_q.block_d[7:0];
		end else begin
			new_e.scale = in_q.block_d[8];
			new_e.issue = in_q.block_d[7:0];
		end
	end

	always_comb begin
		build = 1'b0;
		ram_we = 1'b0;
		mtype = 6'd0;
		mlen = 5'd0;
		nw = 3'd0;
		ctl = '0;
		for (int i = 0; i < 7; i++) wn[i] = 24'd0;
		case (mt)
			MT_REF: begin
				build = 1'b1; mtype = 6'd5; mlen = 5'd3; nw = 3'd3;
			end
			MT_CORR1, MT_CORR2: begin
				ram_we = (state_q == TS_BUILD);
				build = 1'b1; mtype = 6'd9; mlen = 5'd7; nw = 3'd7;
				wn[2] = {new_e.scale, new_e.udre, cur_q, new_e.range_corr};
				wn[3] = {new_e.rate_corr, new_e.issue, new_e.scale, new_e.udre, cur_q};
				wn[4] = {new_e.range_corr, new_e.rate_corr};
				wn[5] = {new_e.issue, new_e.scale, new_e.udre, cur_q,
					new_e.range_corr[15:8]};
				wn[6] = {new_e.range_corr[7:0], new_e.rate_corr, new_e.issue};
			end
			MT_COORD: begin
				if (low != 2'd3) begin
					build = 1'b1; mtype = 6'd3; mlen = 5'd6; nw = 3'd6;
				end
				wn[2] = coord_q[0][31:8];
				wn[3] = {coord_q[0][7:0], coord_q[1][31:16]};
				wn[4] = {coord_q[1][15:0], coord_q[2][31:24]};
				wn[5] = coord_q[2][23:0];
			end
			MT_OPT: begin
				if (low == 2'd3) begin
					build = 1'b1; mtype = 6'd16; mlen = 5'd5; nw = 3'd3;
					wn[2] = {8'h20, 8'h52, 8'h41};
				end else begin
					ctl.status = ST_OPT;
				end
			end
			MT_SKIP: ;
			default: ctl.status = ST_UNASSIGNED;
		endcase
		wn[0] = {PREAMBLE, mtype, sid_q};
		wn[1] = {z_q, seq_q, mlen, health_q};
		ctl.nwords = nw;
		ctl.start = (state_q == TS_BUILD) &&
			((build && oe_q) || ctl.status != ST_DATA);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			TS_IDLE:  if (accept) state_d = TS_BUILD;
			TS_BUILD: state_d = ctl.start ? TS_SEND : TS_IDLE;
			TS_SEND:  if (!fr_busy) state_d = TS_IDLE;
			default:  state_d = TS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= TS_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oe_q <= 1'b1;
			z_q <= '0;
			sid_q <= '0;
			health_q <= '0;
			for (int i = 0; i < 3; i++) coord_q[i] <= '0;
			cur_q <= '0;
			seq_q <= '0;
			vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) oe_q <= cfg_wdata;
			if (accept) begin
				rd_vld_s1 <= vld_q[in_data.block_d[15:11]];
				case (in_data.group_bits[4:2])
					MT_REF: begin
						sid_q <= in_data.block_c[9:0];
						health_q <= in_data.block_d[15:13];
						z_q <= in_data.block_d[12:0];
					end
					MT_CORR1, MT_CORR2: cur_q <= in_data.block_d[15:11];
					MT_COORD: begin
						if (in_data.group_bits[1:0] != 2'd3)
							coord_q[in_data.group_bits[1:0]] <=
								{in_data.block_c, in_data.block_d};
					end
					default: ;
				endcase
			end
			if (state_q == TS_BUILD && build) seq_q <= seq_q + 3'd1;
			if (ram_we) vld_q[cur_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) in_q <= in_data;
		if (state_q == TS_BUILD) begin
			for (int i = 0; i < 7; i++) w_q[i] <= wn[i];
		end
	end

	rasrtcm_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.word_data (w_q[word_idx]),
		.word_idx  (word_idx),
		.busy      (fr_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RASANT to RTCM 2 converter: testbench
// Drives RASANT groups through directed and random phases, predicts the
// framed RTCM 2 byte stream and status words, and checks every output word.
// ---------------------------------------------------------------------------
module tb_top;
	import rasrtcm_pkg::*;

	localparam logic [2:0] MT_SPARE6 = 3'd6;
	localparam logic [2:0] MT_SPARE7 = 3'd7;
	localparam int RTCM_REF_PARAM = 3;
	localparam int RTCM_ASSIST    = 5;
	localparam int RTCM_CORR      = 9;
	localparam int RTCM_TEXT      = 16;
	localparam int IDLE_LIMIT     = 3000;
	localparam int HOLD_CYCLES    = 400;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_data;
	logic      cfg_we = 1'b0;
	logic      cfg_wdata = 1'b0;

	rasant_to_rtcm2_converter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// converter state as predicted
	logic [12:0] zc_m;
	logic [9:0]  sid_m;
	logic [2:0]  health_m;
	logic [31:0] coord_m [3];
	sat_entry_t  sat_m [NUM_SATS];
	logic [4:0]  cur_sat_m;
	logic [2:0]  seq_m;
	logic [1:0]  pbits_m;
	logic        enable_m;
	logic [31:0] frame_w [7];
	out_word_t   byte_q [$];

	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	logic hold_req = 1'b0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_cnt = 0;

	task automatic put_header(input int mtype, input int len);
		frame_w[0] = (32'(PREAMBLE) << 22) | (32'(mtype & 63) << 16) | (32'(sid_m) << 6);
		frame_w[1] = (32'(zc_m) << 17) | (32'(seq_m) << 14) | (32'(len & 31) << 9) |
			(32'(health_m) << 6);
		seq_m = seq_m + 3'd1;
	endtask

	task automatic frame_words(input int n);
		logic [31:0] w;
		logic [5:0]  p, six, r;
		out_word_t   o;
		if (!enable_m) return;
		for (int i = 0; i < n; i++) begin
			w = {pbits_m, 30'b0} | (frame_w[i] & DATA_MASK);
			p = '0;
			for (int j = 0; j < 6; j++) p = {p[4:0], ^(w & PMASK[j])};
			w = w | 32'(p);
			if (w[30]) w = w ^ DATA_MASK;
			pbits_m = w[1:0];
			for (int j = 24; j >= 0; j -= 6) begin
				six = w[j +: 6];
				for (int k = 0; k < 6; k++) r[5 - k] = six[k];
				o.out_byte = {1'b1, r};
				o.last = 1'b0;
				o.status = ST_DATA;
				byte_q.push_back(o);
			end
		end
	endtask

	task automatic predict_group(input in_word_t g);
		logic [2:0]  mt;
		logic [1:0]  lo;
		logic [4:0]  s;
		logic [31:0] sf, ud, pr, rr, io, sv;
		out_word_t   o;
		int          n0;
		n0 = byte_q.size();
		mt = g.group_bits[4:2];
		lo = g.group_bits[1:0];
		o.out_byte = '0;
		o.last = 1'b1;
		case (mt)
			MT_REF: begin
				sid_m = g.block_c[9:0];
				health_m = g.block_d[15:13];
				zc_m = g.block_d[12:0];
				put_header(RTCM_ASSIST, 3);
				frame_w[2] = '0;
				frame_words(3);
			end
			MT_CORR1, MT_CORR2: begin
				s = g.block_d[15:11];
				cur_sat_m = s;
				sat_m[s].udre = lo;
				sat_m[s].range_corr = g.block_c;
				if (mt == MT_CORR1) begin
					sat_m[s].scale = g.block_d[9];
					sat_m[s].rate_corr = g.block_d[7:0];
				end else begin
					sat_m[s].scale = g.block_d[8];
					sat_m[s].issue = g.block_d[7:0];
				end
				sf = 32'(sat_m[s].scale); ud = 32'(sat_m[s].udre);
				pr = 32'(sat_m[s].range_corr); rr = 32'(sat_m[s].rate_corr);
				io = 32'(sat_m[s].issue); sv = 32'(s);
				put_header(RTCM_CORR, 7);
				frame_w[2] = (sf << 29) | (ud << 27) | (sv << 22) | (pr << 6);
				frame_w[3] = (rr << 22) | (io << 14) | (sf << 13) | (ud << 11) | (sv << 6);
				frame_w[4] = (pr << 14) | (rr << 6);
				frame_w[5] = (io << 22) | (sf << 21) | (ud << 19) | (sv << 14) |
					((pr >> 8) << 6);
				frame_w[6] = ((pr & 32'hff) << 22) | (rr << 14) | (io << 6);
				frame_words(7);
			end
			MT_COORD: begin
				if (lo != 2'd3) begin
					coord_m[lo] = {g.block_c, g.block_d};
					put_header(RTCM_REF_PARAM, 6);
					frame_w[2] = (coord_m[0] >> 8) << 6;
					frame_w[3] = ((coord_m[0] & 32'hff) << 22) | ((coord_m[1] >> 16) << 6);
					frame_w[4] = ((coord_m[1] & 32'hffff) << 14) | ((coord_m[2] >> 24) << 6);
					frame_w[5] = (coord_m[2] & 32'hffffff) << 6;
					frame_words(6);
				end
			end
			MT_OPT: begin
				if (lo == 2'd3) begin
					put_header(RTCM_TEXT, 5);
					frame_w[2] = (32'h20 << 22) | (32'h52 << 14) | (32'h41 << 6);
					frame_w[3] = (32'h53 << 22) | (32'h41 << 14) | (32'h4e << 6);
					frame_w[4] = (32'h54 << 22) | (32'h20 << 14);
					frame_words(3);
				end else begin
					o.status = ST_OPT;
					byte_q.push_back(o);
				end
			end
			MT_SKIP: ;
			default: begin
				o.status = ST_UNASSIGNED;
				byte_q.push_back(o);
			end
		endcase
		if (byte_q.size() > n0) byte_q[byte_q.size() - 1].last = 1'b1;
	endtask

	function automatic in_word_t grp(input logic [2:0] mt, input logic [1:0] lo,
			input logic [15:0] c, input logic [15:0] d);
		in_word_t g;
		g.group_bits = {mt, lo};
		g.block_c = c;
		g.block_d = d;
		return g;
	endfunction

	task automatic send_group(input in_word_t g);
		in_data <= g;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_group(g);
		if (burst_left > 0) burst_left--;
		else begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (byte_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_enable(input logic v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		enable_m = v;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_word_t rand_group();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 15) return grp(MT_REF, 2'($urandom), 16'($urandom), 16'($urandom));
		if (sel < 45) return grp(MT_CORR1, 2'($urandom), 16'($urandom), 16'($urandom));
		if (sel < 70) return grp(MT_CORR2, 2'($urandom), 16'($urandom), 16'($urandom));
		if (sel < 85) return grp(MT_COORD, 2'($urandom), 16'($urandom), 16'($urandom));
		if (sel < 92) return grp(MT_OPT, 2'($urandom), 16'($urandom), 16'($urandom));
		return grp(3'($urandom), 2'($urandom), 16'($urandom), 16'($urandom));
	endfunction

	task automatic test_directed();
		send_group(grp(MT_REF, 2'd0, 16'hffff, 16'hffff));
		send_group(grp(MT_REF, 2'd3, 16'h0000, 16'h0000));
		send_group(grp(MT_CORR1, 2'd3, 16'hffff, 16'hffff));
		send_group(grp(MT_CORR2, 2'd0, 16'h0000, 16'hffff));
		send_group(grp(MT_CORR1, 2'd1, 16'h8001, 16'h0200));
		send_group(grp(MT_CORR2, 2'd2, 16'h7ffe, 16'h0100));
		send_group(grp(MT_CORR1, 2'd0, 16'h1234, 16'h0000));
		send_group(grp(MT_COORD, 2'd0, 16'hffff, 16'hffff));
		send_group(grp(MT_COORD, 2'd1, 16'h0000, 16'h0001));
		send_group(grp(MT_COORD, 2'd2, 16'h8000, 16'h0000));
		send_group(grp(MT_COORD, 2'd3, 16'h5555, 16'haaaa));
		for (int f = 0; f < 4; f++) send_group(grp(MT_OPT, 2'(f), 16'h0, 16'h0));
		send_group(grp(MT_SKIP, 2'd1, 16'hffff, 16'hffff));
		send_group(grp(MT_SPARE6, 2'd2, 16'h0, 16'h0));
		send_group(grp(MT_SPARE7, 2'd3, 16'hffff, 16'hffff));
		send_group(grp(MT_OPT, 2'd3, 16'h0, 16'h0));
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) send_group(rand_group());
	endtask

	task automatic test_output_disabled();
		set_enable(1'b0);
		test_random(30);
		set_enable(1'b1);
		test_random(20);
	endtask

	task automatic test_backpressure();
		drain();
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		burst_left = 30;
		for (int i = 0; i < 30; i++) send_group(grp(MT_CORR1, 2'($urandom),
			16'($urandom), 16'($urandom)));
	endtask

	// output stall: long hold on request, otherwise a changing pattern
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= 1'($urandom_range(0, 1));
				default: out_stall <= (mode_cnt % 8) < 5;
			endcase
		end
		if (mode_cnt == 63) stall_mode <= $urandom_range(0, 3);
		mode_cnt <= (mode_cnt + 1) % 64;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (byte_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected output word %p", out_data);
			end else if (out_data !== byte_q[0]) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %p got %p", byte_q[0], out_data);
				void'(byte_q.pop_front());
			end else begin
				void'(byte_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		zc_m = '0; sid_m = '0; health_m = '0; cur_sat_m = '0;
		seq_m = '0; pbits_m = '0; enable_m = 1'b1;
		for (int i = 0; i < 3; i++) coord_m[i] = '0;
		for (int i = 0; i < NUM_SATS; i++) sat_m[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		set_enable(1'b1);
		test_random(150);
		test_output_disabled();
		test_backpressure();
		set_enable(1'b0);
		set_enable(1'b1);
		test_random(180);
		drain();
		repeat (40) @(posedge clk);
		if (errors == 0 && byte_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/rasrtcm_pkg.sv
design/rasrtcm_sat_ram.sv
design/rasrtcm_framer.sv
design/rasant_to_rtcm2_converter.sv
sim/tb_top.sv
